@@ hdl/cqm_pkg.sv @@
// shared types, codes and constants of the claim queue mutex
`timescale 1ns / 1ps

package cqm_pkg;

    localparam int ID_W             = 4;
    localparam int NUM_CLAIMERS_DEF = 16;
    localparam int QUEUE_DEPTH_DEF  = 16;
    localparam int OPCODE_W         = 2;
    localparam int STATUS_W         = 2;
    localparam int PENDING_W        = 5;
    localparam int S_TDATA_W        = 16;
    localparam int S_TUSER_W        = 2;
    localparam int M_TDATA_W        = 24;

    // request opcodes
    localparam logic [OPCODE_W-1:0] OP_ADD      = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_REMOVE   = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_REPLACE  = 2'd2;
    localparam logic [OPCODE_W-1:0] OP_EVALUATE = 2'd3;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_REJECT    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;

    // per cell commands
    localparam logic [1:0] CELL_HOLD       = 2'd0;
    localparam logic [1:0] CELL_LOAD       = 2'd1;
    localparam logic [1:0] CELL_FROM_LEFT  = 2'd2;
    localparam logic [1:0] CELL_FROM_RIGHT = 2'd3;

    // queue actions
    localparam logic [2:0] CH_HOLD       = 3'd0;
    localparam logic [2:0] CH_APPEND     = 3'd1;
    localparam logic [2:0] CH_PUSH       = 3'd2;
    localparam logic [2:0] CH_DROP_MATCH = 3'd3;
    localparam logic [2:0] CH_DROP_FRONT = 3'd4;
    localparam logic [2:0] CH_REPLACE    = 3'd5;

    typedef struct packed {
        logic [2:0]      action;
        logic [ID_W-1:0] probe_id;
        logic [ID_W-1:0] new_id;
    } chain_ctrl_t;

    typedef struct packed {
        logic            found_probe;
        logic            found_new;
        logic [ID_W-1:0] front_id;
    } chain_stat_t;

endpackage

@@ hdl/cqm_cell.sv @@
// one queue cell: holds a claimer id, compares it and shifts with its neighbors
`timescale 1ns / 1ps

module cqm_cell
(
    input  logic                    clk,
    input  logic [1:0]              cmd,
    input  logic                    occupied,
    input  logic [cqm_pkg::ID_W-1:0] left_id,
    input  logic [cqm_pkg::ID_W-1:0] right_id,
    input  logic [cqm_pkg::ID_W-1:0] load_id,
    input  logic [cqm_pkg::ID_W-1:0] probe_id,
    input  logic [cqm_pkg::ID_W-1:0] new_id,
    output logic [cqm_pkg::ID_W-1:0] id,
    output logic                    hit_probe,
    output logic                    hit_new
);

    logic [cqm_pkg::ID_W-1:0] id_reg;
    logic [cqm_pkg::ID_W-1:0] id_next;

    always_comb
    begin
        case (cmd)
            cqm_pkg::CELL_LOAD:       id_next = load_id;
            cqm_pkg::CELL_FROM_LEFT:  id_next = left_id;
            cqm_pkg::CELL_FROM_RIGHT: id_next = right_id;
            default:                  id_next = id_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        id_reg <= id_next;
    end

    assign id        = id_reg;
    assign hit_probe = occupied && (id_reg == probe_id);
    assign hit_new   = occupied && (id_reg == new_id);

endmodule

@@ hdl/cqm_chain.sv @@
// wait queue as a row of cells with the fill count
`timescale 1ns / 1ps

module cqm_chain
#(
    parameter int QUEUE_DEPTH = cqm_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  cqm_pkg::chain_ctrl_t             ctrl,
    output cqm_pkg::chain_stat_t             stat,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0] len,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0] len_next
);

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH+1);

    logic [CNT_W-1:0]              len_reg;
    logic [cqm_pkg::ID_W-1:0]      cell_id [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0]        hit_probe;
    logic [QUEUE_DEPTH-1:0]        hit_new;
    logic [IDX_W-1:0]              match_pos;
    logic [cqm_pkg::ID_W-1:0]      load_id;

    // ids in the queue are unique, so or-ing the hit indexes gives the position
    always_comb
    begin
        match_pos = '0;
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            if (hit_probe[i])
                match_pos = match_pos | IDX_W'(i);
        end
    end

    assign load_id = (ctrl.action == cqm_pkg::CH_REPLACE) ? ctrl.new_id : ctrl.probe_id;

    genvar g;
    generate
        for (g = 0; g < QUEUE_DEPTH; g++)
        begin : g_cell
            logic [1:0]               cmd;
            logic [cqm_pkg::ID_W-1:0] left_id;
            logic [cqm_pkg::ID_W-1:0] right_id;

            assign left_id  = (g == 0) ? ctrl.probe_id : cell_id[(g == 0) ? 0 : g-1];
            assign right_id = cell_id[(g == QUEUE_DEPTH-1) ? g : g+1];

            always_comb
            begin
                cmd = cqm_pkg::CELL_HOLD;
                case (ctrl.action)
                    cqm_pkg::CH_APPEND:
                        if (CNT_W'(g) == len_reg)
                            cmd = cqm_pkg::CELL_LOAD;
                    cqm_pkg::CH_PUSH:
                        cmd = (g == 0) ? cqm_pkg::CELL_LOAD : cqm_pkg::CELL_FROM_LEFT;
                    cqm_pkg::CH_DROP_MATCH:
                        if (IDX_W'(g) >= match_pos)
                            cmd = cqm_pkg::CELL_FROM_RIGHT;
                    cqm_pkg::CH_DROP_FRONT:
                        cmd = cqm_pkg::CELL_FROM_RIGHT;
                    cqm_pkg::CH_REPLACE:
                        if (hit_probe[g])
                            cmd = cqm_pkg::CELL_LOAD;
                    default:
                        cmd = cqm_pkg::CELL_HOLD;
                endcase
            end

            cqm_cell u_cell
            (
                .clk       (clk),
                .cmd       (cmd),
                .occupied  (CNT_W'(g) < len_reg),
                .left_id   (left_id),
                .right_id  (right_id),
                .load_id   (load_id),
                .probe_id  (ctrl.probe_id),
                .new_id    (ctrl.new_id),
                .id        (cell_id[g]),
                .hit_probe (hit_probe[g]),
                .hit_new   (hit_new[g])
            );
        end
    endgenerate

    always_comb
    begin
        case (ctrl.action)
            cqm_pkg::CH_APPEND,
            cqm_pkg::CH_PUSH:       len_next = len_reg + CNT_W'(1);
            cqm_pkg::CH_DROP_MATCH,
            cqm_pkg::CH_DROP_FRONT: len_next = len_reg - CNT_W'(1);
            default:                len_next = len_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            len_reg <= '0;
        else
            len_reg <= len_next;
    end

    assign len              = len_reg;
    assign stat.found_probe = |hit_probe;
    assign stat.found_new   = |hit_new;
    assign stat.front_id    = cell_id[0];

endmodule

@@ hdl/claim_queue_mutex_unit.sv @@
// claim queue mutex top level: lock holder, request decode and result register
`timescale 1ns / 1ps

// Lock with one holder and an ordered wait queue of claimer ids.
// Requests enter on the s_ stream: s_tuser carries the opcode (add, remove,
// replace, evaluate), s_tdata the claimer id, the replacement id and the
// urgent flag. Every request gives exactly one result on the m_ stream with
// grant, evaluate request, status, holder and pending count.
// A request is decoded and applied in the cycle it is accepted; its result
// sits in the output register from the next cycle, and one request is taken
// per cycle while results are taken. The queue is a row of cells that
// compare their ids in parallel and shift to their neighbors.
// s_tready is high while the output register is empty or being read; when
// the receiver stalls, the result is held and no further request is taken.
// Reset frees the lock, empties the queue and drops any waiting result;
// queue entries are not cleared, only the fill count.

module claim_queue_mutex_unit
#(
    parameter int NUM_CLAIMERS = cqm_pkg::NUM_CLAIMERS_DEF,
    parameter int QUEUE_DEPTH  = cqm_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // claimer_id[3:0], new_claimer_id[7:4], urgent[8], zero fill
    input  logic [cqm_pkg::S_TDATA_W-1:0] s_tdata,
    // opcode[1:0]
    input  logic [cqm_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // grant_valid[0], grant_id[4:1], evaluate_request[5], status[7:6],
    // holder_valid[8], holder_id[12:9], pending_count[17:13], zero fill
    output logic [cqm_pkg::M_TDATA_W-1:0] m_tdata
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH+1);

    logic                           accept;
    logic [cqm_pkg::ID_W-1:0]       claimer_id;
    logic [cqm_pkg::ID_W-1:0]       new_claimer_id;
    logic                           urgent;
    logic [cqm_pkg::OPCODE_W-1:0]   opcode;

    logic                           held_reg;
    logic                           held_next;
    logic [cqm_pkg::ID_W-1:0]       holder_reg;
    logic [cqm_pkg::ID_W-1:0]       holder_next;
    logic                           out_valid_reg;
    logic [cqm_pkg::M_TDATA_W-1:0]  out_data_reg;
    logic [cqm_pkg::M_TDATA_W-1:0]  out_data_next;

    cqm_pkg::chain_ctrl_t           ctrl;
    cqm_pkg::chain_stat_t           stat;
    logic [CNT_W-1:0]               len;
    logic [CNT_W-1:0]               len_next;
    logic [CNT_W+cqm_pkg::PENDING_W-1:0] pending_wide;

    logic [2:0]                     action;
    logic [cqm_pkg::STATUS_W-1:0]   status;
    logic                           eval_req;
    logic                           grant;
    logic [cqm_pkg::ID_W-1:0]       grant_id;
    logic                           id_oor;
    logic                           new_id_oor;
    logic                           is_holder;
    logic                           full;

    assign claimer_id     = s_tdata[3:0];
    assign new_claimer_id = s_tdata[7:4];
    assign urgent         = s_tdata[8];
    assign opcode         = s_tuser[1:0];

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    assign id_oor     = 32'(claimer_id) >= NUM_CLAIMERS;
    assign new_id_oor = 32'(new_claimer_id) >= NUM_CLAIMERS;
    assign is_holder  = held_reg && (holder_reg == claimer_id);
    assign full       = len == CNT_W'(QUEUE_DEPTH);

    always_comb
    begin
        action      = cqm_pkg::CH_HOLD;
        status      = cqm_pkg::ST_OK;
        eval_req    = 1'b0;
        grant       = 1'b0;
        grant_id    = '0;
        held_next   = held_reg;
        holder_next = holder_reg;
        case (opcode)
            cqm_pkg::OP_ADD:
            begin
                if (id_oor || full || stat.found_probe)
                    status = cqm_pkg::ST_REJECT;
                else
                begin
                    action   = urgent ? cqm_pkg::CH_PUSH : cqm_pkg::CH_APPEND;
                    eval_req = !held_reg;
                end
            end
            cqm_pkg::OP_REMOVE:
            begin
                if (id_oor)
                    status = cqm_pkg::ST_NOT_FOUND;
                else if (is_holder)
                begin
                    held_next   = 1'b0;
                    holder_next = '0;
                    eval_req    = 1'b1;
                end
                else if (stat.found_probe)
                    action = cqm_pkg::CH_DROP_MATCH;
                else
                    status = cqm_pkg::ST_NOT_FOUND;
            end
            cqm_pkg::OP_REPLACE:
            begin
                if (id_oor || new_id_oor)
                    status = cqm_pkg::ST_NOT_FOUND;
                else if (!is_holder && !stat.found_probe)
                    status = cqm_pkg::ST_NOT_FOUND;
                else if (stat.found_probe && (new_claimer_id != claimer_id) &&
                         stat.found_new)
                    status = cqm_pkg::ST_REJECT;
                else
                begin
                    if (is_holder)
                        holder_next = new_claimer_id;
                    if (stat.found_probe)
                        action = cqm_pkg::CH_REPLACE;
                end
            end
            cqm_pkg::OP_EVALUATE:
            begin
                if (!held_reg && (len != '0))
                begin
                    held_next   = 1'b1;
                    holder_next = stat.front_id;
                    action      = cqm_pkg::CH_DROP_FRONT;
                    grant       = 1'b1;
                    grant_id    = stat.front_id;
                end
            end
            default:
            begin
                action = cqm_pkg::CH_HOLD;
            end
        endcase
    end

    assign ctrl.action   = accept ? action : cqm_pkg::CH_HOLD;
    assign ctrl.probe_id = claimer_id;
    assign ctrl.new_id   = new_claimer_id;

    cqm_chain
    #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    )
    u_chain
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl),
        .stat     (stat),
        .len      (len),
        .len_next (len_next)
    );

    // pending count reports the low bits of the fill count after the request
    assign pending_wide = {{cqm_pkg::PENDING_W{1'b0}}, len_next};

    assign out_data_next = {6'b0,
                            pending_wide[cqm_pkg::PENDING_W-1:0],
                            holder_next,
                            held_next,
                            status,
                            eval_req,
                            grant_id,
                            grant};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg      <= 1'b0;
            holder_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                held_reg   <= held_next;
                holder_reg <= holder_next;
            end
            if (accept)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

@@ hdl/cqm_checker.sv @@
// port level checks of the claim queue mutex, bound to the top level
`timescale 1ns / 1ps

module cqm_checker
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [cqm_pkg::M_TDATA_W-1:0] m_tdata
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // every accepted request shows a result in the next cycle
    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> m_tvalid)
        else $error("accepted request gave no result");

    // a grant leaves the granted claimer as holder
    a_grant_holder: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[0] |-> m_tdata[8] && (m_tdata[12:9] == m_tdata[4:1]))
        else $error("grant does not match holder");

    // a grant comes with ok status and no evaluate request
    a_grant_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[0] |-> !m_tdata[5] && (m_tdata[7:6] == cqm_pkg::ST_OK))
        else $error("grant with bad status");

    // without a holder, the holder id reads zero; status is always a known code
    a_holder_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[8] || (m_tdata[12:9] == '0)) &&
                     ((m_tdata[7:6] == cqm_pkg::ST_OK) ||
                      (m_tdata[7:6] == cqm_pkg::ST_REJECT) ||
                      (m_tdata[7:6] == cqm_pkg::ST_NOT_FOUND)))
        else $error("bad holder id or status");

endmodule

bind claim_queue_mutex_unit cqm_checker u_cqm_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
